// File: rtl/upd_pkg.sv
package upd_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [3:0] HEX_TEN    = 4'd10;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_HEX1,
		MODE_HEX2
	} mode_t;

	// one request: up to two decoded bytes, then an optional terminator
	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [1:0] nbytes;
		logic       term;
	} req_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib >= HEX_TEN) begin
			r = 8'(nib - HEX_TEN) + CH_UPPER_A;
		end else begin
			r = 8'(nib) + CH_ZERO;
		end
		return r;
	endfunction

endpackage

// File: rtl/upd_front.sv
module upd_front import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte
	input  logic       s_tlast,   // end_of_string
	input  logic       q_full,
	output logic       push,
	output req_t       req
);

	mode_t      mode_q, mode_d;
	logic [3:0] nibble_q, nibble_d;
	logic       halted_q, halted_d;
	logic       acc;
	logic       hex_ok;
	logic [3:0] hex_val;

	assign s_tready = !q_full;
	assign acc      = s_tvalid && !q_full;

	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (s_tdata inside {[8'h30:8'h39]}) begin
			hex_val = 4'(s_tdata - CH_ZERO);
		end else if (s_tdata inside {[8'h61:8'h66]}) begin
			hex_val = 4'(s_tdata - CH_LOWER_A) + HEX_TEN;
		end else if (s_tdata inside {[8'h41:8'h46]}) begin
			hex_val = 4'(s_tdata - CH_UPPER_A) + HEX_TEN;
		end else begin
			hex_ok = 1'b0;
		end
	end

	always_comb begin
		mode_d     = mode_q;
		nibble_d   = nibble_q;
		halted_d   = halted_q;
		req.byte0  = s_tdata;
		req.byte1  = hex_char(nibble_q);
		req.nbytes = 2'd0;
		req.term   = s_tlast;
		if (!halted_q) begin
			if (s_tdata == CH_NUL) begin
				halted_d = 1'b1;
			end else begin
				case (mode_q)
					MODE_HEX1, MODE_HEX2: begin
						mode_d = MODE_NORMAL;
						if (hex_ok) begin
							if (mode_q == MODE_HEX1) begin
								nibble_d = hex_val;
								mode_d   = MODE_HEX2;
							end else begin
								req.byte0  = {nibble_q, hex_val};
								req.nbytes = 2'd1;
							end
						end else begin
							// bad escape
							req.byte0  = CH_PERCENT;
							req.nbytes = (mode_q == MODE_HEX2) ? 2'd2 : 2'd1;
						end
					end
					default: begin
						if (s_tdata == CH_PERCENT) begin
							nibble_d = 4'd0;
							mode_d   = MODE_HEX1;
						end else if (s_tdata == CH_PLUS) begin
							req.byte0  = CH_SPACE;
							req.nbytes = 2'd1;
						end else begin
							req.nbytes = 2'd1;
						end
					end
				endcase
			end
		end
		if (s_tlast) begin
			mode_d   = MODE_NORMAL;
			nibble_d = 4'd0;
			halted_d = 1'b0;
		end
	end

	assign push = acc && (req.nbytes != 2'd0 || req.term);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NORMAL;
			nibble_q <= 4'd0;
			halted_q <= 1'b0;
		end else if (acc) begin
			mode_q   <= mode_d;
			nibble_q <= nibble_d;
			halted_q <= halted_d;
		end
	end

endmodule

// File: rtl/upd_queue.sv
module upd_queue import upd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  req_t              push_req,
	input  logic              pop,
	output req_t              head,
	output logic              empty,
	output logic              full,
	output logic [QCNT_W-1:0] count
);

	req_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/upd_back.sv
module upd_back import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  req_t       head,
	input  logic       empty,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic       m_tlast,   // last_of_run
	output logic       m_tuser    // is_terminator
);

	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic       m_tlast_q;
	logic       m_tuser_q;
	logic [1:0] idx_q;
	logic       load;
	logic [1:0] total;
	logic       cur_term;
	logic       cur_last;
	logic [7:0] cur_byte;

	assign load     = !m_tvalid_q || m_tready;
	assign total    = head.nbytes + 2'(head.term);
	assign cur_term = (idx_q >= head.nbytes);
	assign cur_last = (2'(idx_q + 2'd1) == total);
	assign cur_byte = cur_term ? CH_NUL : (idx_q[0] ? head.byte1 : head.byte0);
	assign pop      = load && !empty && cur_last;

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			m_tdata_q <= cur_byte;
			m_tlast_q <= cur_last;
			m_tuser_q <= cur_term;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			idx_q      <= 2'd0;
		end else if (load) begin
			m_tvalid_q <= !empty;
			if (!empty) begin
				idx_q <= cur_last ? 2'd0 : 2'(idx_q + 2'd1);
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

endmodule

// File: rtl/url_percent_decoder.sv
// URL percent decoder: takes one encoded byte per cycle on the slave side and
// delivers decoded bytes on the master side, one per cycle while m_tready is
// high. A byte yields zero to three results ('%' escape errors give up to two,
// end of string adds a zero terminator flagged on tuser); tlast marks the final
// result of each input byte. The front classifier decodes and holds escape state,
// and hands each request to a four-entry queue; the back serializer drains it
// through an output register, so each result passes through a queue entry and
// the output register before it reaches the master side, and input stalls only
// when the queue is full, i.e. when downstream falls behind the result rate.
module url_percent_decoder import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte
	input  logic       s_tlast,   // end_of_string
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic       m_tlast,   // last_of_run
	output logic       m_tuser    // is_terminator
);

	logic              push;
	req_t              req;
	req_t              head;
	logic              pop;
	logic              q_empty;
	logic              q_full;
	logic [QCNT_W-1:0] q_count;

	upd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.req      (req)
	);

	upd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (req),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full),
		.count    (q_count)
	);

	upd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (q_empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (q_count != QCNT_W'(QDEPTH)))
		else $error("request queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("request queue underflow");

	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && m_tdata == CH_NUL))
		else $error("terminator not last or not zero");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCNT_W'(QDEPTH))
		else $error("queue count out of range");

endmodule

// File: sim/url_percent_decoder_tb.sv
module url_percent_decoder_tb import upd_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_term;
		logic       last;
	} dec_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;   // in_byte
	logic       s_tlast = 1'b0;    // end_of_string
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // out_byte
	logic       m_tlast;           // last_of_run
	logic       m_tuser;           // is_terminator

	url_percent_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	// decoder state as predicted
	mode_t      pred_mode = MODE_NORMAL;
	logic [3:0] pred_nibble = 4'h0;
	logic       pred_halted = 1'b0;

	dec_result_t decoded_q[$];
	dec_result_t got_exp;

	int err_cnt = 0;
	int checked_cnt = 0;
	int sent_cnt = 0;
	int string_cnt = 0;
	int cycle_cnt = 0;

	int send_idle = 0;
	int recv_stall = 0;
	int hold_len = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int hex_val(input logic [7:0] c);
		int v;
		v = -1;
		if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) begin
			v = int'(c - CH_ZERO);
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5) begin
			v = int'(c - CH_LOWER_A) + int'(HEX_TEN);
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) begin
			v = int'(c - CH_UPPER_A) + int'(HEX_TEN);
		end
		return v;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] nib, input bit lower);
		logic [7:0] r;
		if (nib >= HEX_TEN) begin
			r = {4'h0, nib} - {4'h0, HEX_TEN} + (lower ? CH_LOWER_A : CH_UPPER_A);
		end else begin
			r = {4'h0, nib} + CH_ZERO;
		end
		return r;
	endfunction

	// expected results for one accepted byte
	function automatic void decode_step(input logic [7:0] c, input logic eos);
		dec_result_t r[3];
		int n;
		int v;
		n = 0;
		if (!pred_halted) begin
			if (c == CH_NUL) begin
				pred_halted = 1'b1;
			end else if (pred_mode == MODE_HEX1 || pred_mode == MODE_HEX2) begin
				v = hex_val(c);
				if (v >= 0) begin
					if (pred_mode == MODE_HEX1) begin
						pred_nibble = 4'(v);
						pred_mode = MODE_HEX2;
					end else begin
						r[n] = '{{pred_nibble, 4'(v)}, 1'b0, 1'b0};
						n++;
						pred_mode = MODE_NORMAL;
					end
				end else begin
					r[n] = '{CH_PERCENT, 1'b0, 1'b0};
					n++;
					if (pred_mode == MODE_HEX2) begin
						r[n] = '{hex_digit(pred_nibble, 1'b0), 1'b0, 1'b0};
						n++;
					end
					pred_mode = MODE_NORMAL;
				end
			end else if (c == CH_PERCENT) begin
				pred_nibble = 4'h0;
				pred_mode = MODE_HEX1;
			end else if (c == CH_PLUS) begin
				r[n] = '{CH_SPACE, 1'b0, 1'b0};
				n++;
			end else begin
				r[n] = '{c, 1'b0, 1'b0};
				n++;
			end
		end
		if (eos) begin
			r[n] = '{CH_NUL, 1'b1, 1'b0};
			n++;
			pred_mode = MODE_NORMAL;
			pred_nibble = 4'h0;
			pred_halted = 1'b0;
		end
		if (n > 0) begin
			r[n - 1].last = 1'b1;
		end
		for (int i = 0; i < n; i++) begin
			decoded_q.push_back(r[i]);
		end
	endfunction

	// request monitor and result checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				decode_step(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				if (decoded_q.size() == 0) begin
					$error("unexpected result: out_byte %h is_terminator %b last_of_run %b",
						m_tdata, m_tuser, m_tlast);
					err_cnt++;
				end else begin
					got_exp = decoded_q.pop_front();
					checked_cnt++;
					if (m_tdata !== got_exp.out_byte) begin
						$error("out_byte: expected %h, got %h", got_exp.out_byte, m_tdata);
						err_cnt++;
					end
					if (m_tuser !== got_exp.is_term) begin
						$error("is_terminator: expected %b, got %b", got_exp.is_term, m_tuser);
						err_cnt++;
					end
					if (m_tlast !== got_exp.last) begin
						$error("last_of_run: expected %b, got %b", got_exp.last, m_tlast);
						err_cnt++;
					end
				end
			end
		end
	end

	// receiver: random stalls plus an occasional long hold
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAIL url_percent_decoder");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eos);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eos;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_cnt++;
		if (eos) begin
			string_cnt++;
		end
	endtask

	task automatic send_text(input string s, input bit eos_last);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i], eos_last && (i == s.len() - 1));
		end
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic send_random_string();
		logic [7:0] str[$];
		int tokens;
		int kind;
		logic [7:0] b;
		tokens = $urandom_range(1, 5);
		for (int t = 0; t < tokens; t++) begin
			kind = $urandom_range(99);
			if (kind < 35) begin
				str.push_back(CH_PERCENT);
				str.push_back(hex_digit(4'($urandom_range(15)), 1'($urandom_range(1))));
				str.push_back(hex_digit(4'($urandom_range(15)), 1'($urandom_range(1))));
			end else if (kind < 45) begin
				str.push_back(CH_PLUS);
			end else if (kind < 55) begin
				// broken escape, with or without a first digit
				str.push_back(CH_PERCENT);
				if ($urandom_range(1)) begin
					str.push_back(hex_digit(4'($urandom_range(15)), 1'($urandom_range(1))));
				end
				do begin
					b = 8'($urandom_range(1, 255));
				end while (hex_val(b) >= 0);
				str.push_back(b);
			end else if (kind < 59) begin
				str.push_back(CH_NUL);
			end else begin
				str.push_back(8'($urandom_range(1, 255)));
			end
		end
		// sometimes leave an escape open at the end
		kind = $urandom_range(99);
		if (kind < 8) begin
			str.push_back(CH_PERCENT);
		end else if (kind < 14) begin
			str.push_back(CH_PERCENT);
			str.push_back(hex_digit(4'($urandom_range(15)), 1'($urandom_range(1))));
		end
		for (int i = 0; i < str.size(); i++) begin
			send_byte(str[i], i == str.size() - 1);
		end
	endtask

	task automatic test_directed();
		send_idle = 0;
		recv_stall = 0;
		send_text("+%4a%F0%00", 1'b1);
		send_text("%G", 1'b1);
		send_text("%4z", 1'b1);
		send_text("%b%", 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(CH_NUL, 1'b0);
		send_byte(8'h79, 1'b1);
		send_text("%4", 1'b1);
		send_byte(CH_NUL, 1'b1);
		wait_drain();
	endtask

	task automatic test_random(input int n_bytes, input int idle_pct, input int stall_pct);
		int start;
		send_idle = idle_pct;
		recv_stall = stall_pct;
		start = sent_cnt;
		while (sent_cnt - start < n_bytes) begin
			send_random_string();
		end
		wait_drain();
	endtask

	task automatic test_backpressure();
		int start;
		send_idle = 0;
		recv_stall = 0;
		hold_len <= 80;
		hold_req <= hold_req + 1;
		@(posedge clk);
		start = sent_cnt;
		while (sent_cnt - start < 15) begin
			send_random_string();
		end
		wait_drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(30, 0, 0);
		test_random(30, 49, 0);
		test_random(30, 0, 49);
		test_random(30, 32, 32);
		test_backpressure();
		$display("ran %0d strings, %0d bytes in, %0d results checked", string_cnt, sent_cnt,
			checked_cnt);
		$display("covered escapes, broken escapes, halts, open escapes and a long output hold");
		if (err_cnt == 0) begin
			$display("PASS url_percent_decoder");
		end else begin
			$display("FAIL url_percent_decoder");
		end
		$finish;
	end

endmodule
